>>> src/lcfs_pkg.sv
// lcfs_pkg: shared types and constants of the led chain frame serializer
`timescale 1ns / 1ps
package lcfs_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int BRIGHT_W = 5;
    localparam int POS_W = 8;
    // step counter covers the start run and the longest end run (16 words)
    localparam int CNT_W = 5;
    localparam int START_BYTES = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] HEADER_MARK = 8'hE0;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLUE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GREEN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [BYTE_W-1:0] wire_byte;
        logic [KIND_W-1:0] byte_kind;
        logic              last_of_run;
    } t_word;

    // classified pixel handed from the front to the back
    typedef struct packed {
        t_pixel            pixel;
        logic [BYTE_W-1:0] header;
        logic              is_first;
        logic              is_last;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_BLUE,
        PH_GREEN,
        PH_RED,
        PH_END
    } t_phase;

endpackage

>>> src/lcfs_front.sv
// lcfs_front: accepts pixels, tracks the frame position and builds commands
`timescale 1ns / 1ps
module lcfs_front #(
    parameter int LED_COUNT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  lcfs_pkg::t_pixel               i_pixel,
    input  logic                           i_cfg_we,
    input  logic [lcfs_pkg::BRIGHT_W-1:0]  i_cfg_wdata,
    output logic                           o_cmd_push,
    output lcfs_pkg::t_cmd                 o_cmd,
    input  logic                           i_cmd_full
);

    logic [lcfs_pkg::POS_W-1:0]    r_pos;
    logic [lcfs_pkg::POS_W-1:0]    n_pos;
    logic [lcfs_pkg::BRIGHT_W-1:0] r_bright;
    logic                          w_accept;
    logic                          w_last;

    assign full     = i_cmd_full;
    assign w_accept = push && !i_cmd_full;
    // last pixel of the frame, also when the position ever runs past the chain
    assign w_last   = ({1'b0, r_pos} + 9'd1) >= 9'(LED_COUNT);
    assign n_pos    = w_last ? '0 : r_pos + 1'b1;

    always_comb begin
        o_cmd_push     = w_accept;
        o_cmd.pixel    = i_pixel;
        o_cmd.header   = lcfs_pkg::HEADER_MARK | {3'b000, r_bright};
        o_cmd.is_first = (r_pos == '0);
        o_cmd.is_last  = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_bright <= '1;
        end else begin
            if (w_accept) begin
                r_pos <= n_pos;
            end
            if (i_cfg_we) begin
                r_bright <= i_cfg_wdata;
            end
        end
    end

    a_pos_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < 9'(LED_COUNT))
        else $error("pixel position ran past the chain");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_last |=> r_pos == '0)
        else $error("position did not wrap after the last pixel");

    a_first_after_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_last |=> r_pos != '0)
        else $error("position wrapped before the last pixel");

endmodule

>>> src/lcfs_cmd_fifo.sv
// lcfs_cmd_fifo: short command queue between front and back
`timescale 1ns / 1ps
module lcfs_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lcfs_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output lcfs_pkg::t_cmd o_data,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(lcfs_pkg::QUEUE_DEPTH);

    lcfs_pkg::t_cmd   r_mem [lcfs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (PTR_W+1)'(lcfs_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(lcfs_pkg::QUEUE_DEPTH))
        else $error("command queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_count))
        else $error("command queue pointers disagree with count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push && !w_do_pop |=> !o_empty)
        else $error("queue empty after a lone push");

endmodule

>>> src/lcfs_back.sv
// lcfs_back: expands one command into its run of wire words
`timescale 1ns / 1ps
module lcfs_back #(
    parameter int END_BYTES = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lcfs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           empty,
    input  logic           pop,
    output lcfs_pkg::t_word o_word
);

    lcfs_pkg::t_phase            r_phase;
    lcfs_pkg::t_phase            n_phase;
    logic [lcfs_pkg::CNT_W-1:0]  r_cnt;
    logic [lcfs_pkg::CNT_W-1:0]  n_cnt;
    logic                        r_busy;
    logic                        n_busy;
    lcfs_pkg::t_cmd              r_cmd;
    lcfs_pkg::t_cmd              n_cmd;
    logic                        r_out_valid;
    lcfs_pkg::t_word             r_out;
    lcfs_pkg::t_word             w_word;
    logic                        w_load;
    logic                        w_done;
    logic                        w_take;

    assign empty  = !r_out_valid;
    assign o_word = r_out;
    assign w_load = r_busy && (!r_out_valid || pop);

    always_comb begin
        w_word.wire_byte = lcfs_pkg::ZERO_BYTE;
        w_word.byte_kind = lcfs_pkg::KIND_START;
        w_done           = 1'b0;
        n_phase          = r_phase;
        n_cnt            = r_cnt;
        unique case (r_phase)
            lcfs_pkg::PH_START: begin
                w_word.byte_kind = lcfs_pkg::KIND_START;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lcfs_pkg::CNT_W'(lcfs_pkg::START_BYTES - 1)) begin
                    n_phase = lcfs_pkg::PH_HEADER;
                    n_cnt   = '0;
                end
            end
            lcfs_pkg::PH_HEADER: begin
                w_word.wire_byte = r_cmd.header;
                w_word.byte_kind = lcfs_pkg::KIND_HEADER;
                n_phase = lcfs_pkg::PH_BLUE;
            end
            lcfs_pkg::PH_BLUE: begin
                w_word.wire_byte = r_cmd.pixel.blue;
                w_word.byte_kind = lcfs_pkg::KIND_BLUE;
                n_phase = lcfs_pkg::PH_GREEN;
            end
            lcfs_pkg::PH_GREEN: begin
                w_word.wire_byte = r_cmd.pixel.green;
                w_word.byte_kind = lcfs_pkg::KIND_GREEN;
                n_phase = lcfs_pkg::PH_RED;
            end
            lcfs_pkg::PH_RED: begin
                w_word.wire_byte = r_cmd.pixel.red;
                w_word.byte_kind = lcfs_pkg::KIND_RED;
                w_done  = !r_cmd.is_last || (END_BYTES == 0);
                n_phase = lcfs_pkg::PH_END;
                n_cnt   = '0;
            end
            lcfs_pkg::PH_END: begin
                w_word.byte_kind = lcfs_pkg::KIND_END;
                w_done = (r_cnt == lcfs_pkg::CNT_W'(END_BYTES - 1));
                n_cnt  = r_cnt + 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        w_word.last_of_run = w_done;

        w_take = i_cmd_valid && (!r_busy || (w_load && w_done));
        n_busy = r_busy;
        n_cmd  = r_cmd;
        if (w_take) begin
            n_busy  = 1'b1;
            n_cmd   = i_cmd;
            n_phase = i_cmd.is_first ? lcfs_pkg::PH_START : lcfs_pkg::PH_HEADER;
            n_cnt   = '0;
        end else if (w_load && w_done) begin
            n_busy = 1'b0;
        end else if (!w_load) begin
            n_phase = r_phase;
            n_cnt   = r_cnt;
        end
        o_cmd_pop = w_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lcfs_pkg::PH_HEADER;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_word;
        end
    end

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last_of_run |->
            r_out.byte_kind == lcfs_pkg::KIND_RED || r_out.byte_kind == lcfs_pkg::KIND_END)
        else $error("run ended on a word that cannot end it");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.byte_kind == lcfs_pkg::KIND_END ||
            r_out.byte_kind == lcfs_pkg::KIND_START) |-> r_out.wire_byte == '0)
        else $error("start or end word not zero");

    a_end_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == lcfs_pkg::PH_END |-> r_cmd.is_last)
        else $error("end run for a pixel that is not last");

    a_start_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == lcfs_pkg::PH_START |->
            r_cmd.is_first && r_cnt < lcfs_pkg::CNT_W'(lcfs_pkg::START_BYTES))
        else $error("start run out of place");

endmodule

>>> src/led_chain_frame_serializer.sv
// led_chain_frame_serializer: top level of the led chain frame serializer
`timescale 1ns / 1ps
// Turns one pixel (red, green, blue) per input word into the byte words of a
// two-wire LED strip frame for a chain of LED_COUNT LEDs. The first pixel of a
// frame brings four zero start words, every pixel brings a header word
// (0xE0 with the 5-bit global brightness) then blue, green and red, and the
// last pixel of the frame brings (LED_COUNT+14)/16 zero end words; the final
// word of each pixel's run carries last_of_run. Each word is meant to be
// shifted onto the data line MSB first. Timing: the back end emits one word
// per clock from its output register while pop is held high and commands
// wait in the queue; the front accepts a new pixel every cycle the two-entry
// command queue has room, also while words of earlier pixels wait. The
// brightness register resets to 31 and is sampled when a pixel is accepted.
module led_chain_frame_serializer #(
    parameter int LED_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel words in
    input  logic                          push,
    output logic                          full,
    input  lcfs_pkg::t_pixel              i_pixel,
    // result words out
    output logic                          empty,
    input  logic                          pop,
    output lcfs_pkg::t_word               o_word,
    // brightness register
    input  logic                          i_cfg_we,
    input  logic [lcfs_pkg::BRIGHT_W-1:0] i_cfg_wdata
);

    // number of zero words closing a frame
    localparam int END_BYTES = (LED_COUNT + 14) / 16;

    logic           w_cmd_push;
    lcfs_pkg::t_cmd w_cmd_in;
    logic           w_cmd_full;
    logic           w_cmd_pop;
    lcfs_pkg::t_cmd w_cmd_out;
    logic           w_cmd_empty;

    // front: position tracking and frame classification
    lcfs_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in),
        .i_cmd_full  (w_cmd_full)
    );

    // decoupling queue
    lcfs_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // back: word sequencer with output register
    lcfs_back #(
        .END_BYTES (END_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_word      (o_word)
    );

endmodule
